>>> design/dtps_pkg.sv
// Shared types and constants of the two-context priority task stepper.
package dtps_pkg;

  localparam int unsigned ValueW    = 16;
  localparam int unsigned PriW      = 8;
  localparam int unsigned StepW     = 8;
  localparam int unsigned SquareW   = 31;
  localparam int unsigned QueueDepth = 2;

  // Result codes of the kind field.
  typedef enum logic [1:0] {
    KIND_ADD_OK   = 2'd0,
    KIND_ADD_FULL = 2'd1,
    KIND_STEP     = 2'd2,
    KIND_FINISH   = 2'd3
  } kind_e;

  // Request codes of the req_type field.
  typedef enum logic {
    REQ_ADD   = 1'b0,
    REQ_ROUND = 1'b1
  } req_e;

  // Commands that the sequencer gives to one context table.
  typedef enum logic [1:0] {
    TBL_NONE   = 2'd0,
    TBL_APPEND = 2'd1,
    TBL_STEP   = 2'd2,
    TBL_REMOVE = 2'd3
  } tbl_op_e;

  // Classified request held in the queue between front and back.
  typedef struct packed {
    req_e                     req;
    logic                     ctx;
    logic signed [ValueW-1:0] value;
    logic [PriW-1:0]          pri;
    logic [StepW-1:0]         steps;
  } cmd_t;

  // Write side of a context table.
  typedef struct packed {
    tbl_op_e                  op;
    logic signed [ValueW-1:0] value;
    logic [PriW-1:0]          pri;
    logic [StepW-1:0]         steps;
    logic [StepW-1:0]         prog;
  } tbl_wr_t;

  // Read side of a context table: one entry at the addressed slot.
  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic [PriW-1:0]          pri;
    logic [StepW-1:0]         total;
    logic [StepW-1:0]         prog;
  } tbl_rd_t;

endpackage

>>> design/dtps_front.sv
// Front end: accepts request transfers, classifies them and queues them for the back end.
module dtps_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         req_type_i,
  input  logic                         thread_select_i,
  input  logic signed [15:0]           task_value_i,
  input  logic [7:0]                   task_priority_i,
  input  logic [7:0]                   task_steps_i,
  output logic                         cmd_valid_o,
  output dtps_pkg::cmd_t               cmd_o,
  input  logic                         cmd_pop_i
);
  import dtps_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;
  cmd_t            cmd_in;

  always_comb begin
    cmd_in.req   = req_e'(req_type_i);
    cmd_in.ctx   = thread_select_i;
    cmd_in.value = task_value_i;
    cmd_in.pri   = task_priority_i;
    cmd_in.steps = task_steps_i;
  end

  assign in_ready_o  = (cnt_q != CntW'(QueueDepth));
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= PtrW'((32'(wr_ptr_q) + 1) % QueueDepth);
      if (pop)  rd_ptr_q <= PtrW'((32'(rd_ptr_q) + 1) % QueueDepth);
      if (push && !pop) cnt_q <= cnt_q + CntW'(1);
      else if (pop && !push) cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= cmd_in;
  end

endmodule

>>> design/dtps_table.sv
// One context's age-ordered task table with append, step and compacting removal.
module dtps_table #(
  parameter int unsigned N    = 8,
  parameter int unsigned IdxW = (N > 1) ? $clog2(N) : 1,
  parameter int unsigned CntW = $clog2(N + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dtps_pkg::tbl_wr_t     wr_i,
  input  logic [IdxW-1:0]       idx_i,
  output logic [CntW-1:0]       cnt_o,
  output dtps_pkg::tbl_rd_t     rd_o
);
  import dtps_pkg::*;

  logic signed [ValueW-1:0] value_q [N];
  logic [PriW-1:0]          pri_q   [N];
  logic [StepW-1:0]         total_q [N];
  logic [StepW-1:0]         prog_q  [N];
  logic [CntW-1:0]          cnt_q;

  assign cnt_o       = cnt_q;
  assign rd_o.value  = value_q[idx_i];
  assign rd_o.pri    = pri_q[idx_i];
  assign rd_o.total  = total_q[idx_i];
  assign rd_o.prog   = prog_q[idx_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      unique case (wr_i.op)
        TBL_APPEND: cnt_q <= cnt_q + CntW'(1);
        TBL_REMOVE: cnt_q <= cnt_q - CntW'(1);
        TBL_STEP, TBL_NONE: cnt_q <= cnt_q;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // Entries are packed from slot 0 (oldest); a removal pulls younger entries down.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < N; i++) begin
      unique case (wr_i.op)
        TBL_APPEND: begin
          if (CntW'(i) == cnt_q) begin
            value_q[i] <= wr_i.value;
            pri_q[i]   <= wr_i.pri;
            total_q[i] <= wr_i.steps;
            prog_q[i]  <= '0;
          end
        end
        TBL_STEP: begin
          if (IdxW'(i) == idx_i) prog_q[i] <= wr_i.prog;
        end
        TBL_REMOVE: begin
          if ((i + 1 < N) && (i >= int'(idx_i))) begin
            value_q[i] <= value_q[(i + 1) % N];
            pri_q[i]   <= pri_q[(i + 1) % N];
            total_q[i] <= total_q[(i + 1) % N];
            prog_q[i]  <= prog_q[(i + 1) % N];
          end
        end
        TBL_NONE: ;
        default: ;
      endcase
    end
  end

endmodule

>>> design/dtps_back.sv
// Back end: sequencer that runs adds and rounds on the tables and drives the result register.
module dtps_back #(
  parameter int unsigned N    = 8,
  parameter int unsigned IdxW = (N > 1) ? $clog2(N) : 1,
  parameter int unsigned CntW = $clog2(N + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cmd_valid_i,
  input  dtps_pkg::cmd_t         cmd_i,
  output logic                   cmd_pop_o,
  output dtps_pkg::tbl_wr_t      wr_o [2],
  output logic [IdxW-1:0]        idx_o,
  input  logic [CntW-1:0]        cnt_i [2],
  input  dtps_pkg::tbl_rd_t      rd_i [2],
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [1:0]             kind_o,
  output logic                   thread_o,
  output logic signed [15:0]     out_value_o,
  output logic [7:0]             out_priority_o,
  output logic [7:0]             step_done_o,
  output logic [7:0]             total_steps_o,
  output logic [30:0]            square_result_o,
  output logic                   last_o
);
  import dtps_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ADD  = 6'b000010,
    S_PICK = 6'b000100,
    S_SCAN = 6'b001000,
    S_STEP = 6'b010000,
    S_EMIT = 6'b100000
  } state_e;

  state_e                state_q, state_d;
  cmd_t                  cmd_q;
  logic                  ctx_q, ctx_d;
  logic [CntW-1:0]       scan_q, scan_d;
  logic [IdxW-1:0]       best_q, best_d;
  logic [PriW-1:0]       best_pri_q, best_pri_d;

  tbl_rd_t               rec_q;
  logic [StepW-1:0]      done_q;
  logic                  fin_q;
  logic [SquareW-1:0]    sq_q;

  logic                  out_valid_q;
  kind_e                 kind_q;
  logic                  thread_q, last_q;
  logic signed [ValueW-1:0] value_q;
  logic [PriW-1:0]       pri_q;
  logic [StepW-1:0]      step_done_q, total_q;
  logic [SquareW-1:0]    square_q;

  logic                  out_free, load;
  tbl_rd_t               rd;
  logic [CntW-1:0]       cnt;
  logic                  full;
  logic [StepW-1:0]      done;
  logic                  fin;
  logic [ValueW-1:0]     mag;
  logic [2*ValueW-1:0]   prod;

  assign out_free = !out_valid_q || out_ready_i;
  assign rd       = rd_i[ctx_q];
  assign cnt      = cnt_i[ctx_q];
  assign full     = (cnt_i[cmd_q.ctx] == CntW'(N));
  assign done     = rd.prog + StepW'(1);
  assign fin      = (done >= rd.total);
  assign mag      = rd.value[ValueW-1] ? ValueW'(-rd.value) : ValueW'(rd.value);
  assign prod     = mag * mag;

  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i;
  assign load      = out_free && ((state_q == S_ADD) || (state_q == S_EMIT));

  always_comb begin
    state_d    = state_q;
    ctx_d      = ctx_q;
    scan_d     = scan_q;
    best_d     = best_q;
    best_pri_d = best_pri_q;
    idx_o      = '0;
    for (int c = 0; c < 2; c++) begin
      wr_o[c].op    = TBL_NONE;
      wr_o[c].value = cmd_q.value;
      wr_o[c].pri   = cmd_q.pri;
      wr_o[c].steps = cmd_q.steps;
      wr_o[c].prog  = done;
    end
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          ctx_d   = 1'b0;
          state_d = (cmd_i.req == REQ_ADD) ? S_ADD : S_PICK;
        end
      end
      S_ADD: begin
        if (out_free) begin
          if (!full) wr_o[cmd_q.ctx].op = TBL_APPEND;
          state_d = S_IDLE;
        end
      end
      S_PICK: begin
        idx_o = '0;
        if (cnt == '0) begin
          if (ctx_q) state_d = S_IDLE;
          else       ctx_d   = 1'b1;
        end else begin
          best_d     = '0;
          best_pri_d = rd.pri;
          scan_d     = CntW'(1);
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        idx_o = scan_q[IdxW-1:0];
        if (scan_q < cnt) begin
          if (rd.pri > best_pri_q) begin
            best_d     = scan_q[IdxW-1:0];
            best_pri_d = rd.pri;
          end
          scan_d = scan_q + CntW'(1);
        end else begin
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        idx_o            = best_q;
        wr_o[ctx_q].op   = fin ? TBL_REMOVE : TBL_STEP;
        state_d          = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          if (ctx_q) begin
            state_d = S_IDLE;
          end else begin
            ctx_d   = 1'b1;
            state_d = S_PICK;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load)             out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    ctx_q      <= ctx_d;
    scan_q     <= scan_d;
    best_q     <= best_d;
    best_pri_q <= best_pri_d;
    if (cmd_pop_o) cmd_q <= cmd_i;
    if (state_q == S_STEP) begin
      rec_q  <= rd;
      done_q <= done;
      fin_q  <= fin;
      sq_q   <= fin ? prod[SquareW-1:0] : '0;
    end
    if (load) begin
      if (state_q == S_ADD) begin
        kind_q      <= full ? KIND_ADD_FULL : KIND_ADD_OK;
        thread_q    <= cmd_q.ctx;
        value_q     <= cmd_q.value;
        pri_q       <= cmd_q.pri;
        step_done_q <= '0;
        total_q     <= cmd_q.steps;
        square_q    <= '0;
        last_q      <= 1'b1;
      end else begin
        kind_q      <= fin_q ? KIND_FINISH : KIND_STEP;
        thread_q    <= ctx_q;
        value_q     <= rec_q.value;
        pri_q       <= rec_q.pri;
        step_done_q <= done_q;
        total_q     <= rec_q.total;
        square_q    <= sq_q;
        // Context 1 never changes while context 0 is served.
        last_q      <= ctx_q || (cnt_i[1] == '0);
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign thread_o        = thread_q;
  assign out_value_o     = value_q;
  assign out_priority_o  = pri_q;
  assign step_done_o     = step_done_q;
  assign total_steps_o   = total_q;
  assign square_result_o = square_q;
  assign last_o          = last_q;

endmodule

>>> design/dual_thread_priority_task_stepper_core.sv
// Two-context priority task stepper core. The back end handles one request at a time: an add
// appends to its context's table unless full and loads the result register; a round serves
// each context that holds tasks in turn with the one-entry-per-cycle priority scan, steps the
// chosen task and emits its result. Up to two requests wait in the front queue.
// Reset (rst_ni, asynchronous, active low) empties both tables, the queue and the result reg.
module dual_thread_priority_task_stepper_core #(
  parameter int unsigned TASKS_PER_CONTEXT = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               req_type_i,
  input  logic               thread_select_i,
  input  logic signed [15:0] task_value_i,
  input  logic [7:0]         task_priority_i,
  input  logic [7:0]         task_steps_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         kind_o,
  output logic               thread_o,
  output logic signed [15:0] out_value_o,
  output logic [7:0]         out_priority_o,
  output logic [7:0]         step_done_o,
  output logic [7:0]         total_steps_o,
  output logic [30:0]        square_result_o,
  output logic               last_o
);
  import dtps_pkg::*;

  // Slot index and fill-count widths of one context table.
  localparam int unsigned IdxW = (TASKS_PER_CONTEXT > 1) ? $clog2(TASKS_PER_CONTEXT) : 1;
  localparam int unsigned CntW = $clog2(TASKS_PER_CONTEXT + 1);

  logic            cmd_valid, cmd_pop;
  cmd_t            cmd;
  tbl_wr_t         tbl_wr  [2];
  tbl_rd_t         tbl_rd  [2];
  logic [CntW-1:0] tbl_cnt [2];
  logic [IdxW-1:0] tbl_idx;

  // The front end takes request transfers whenever its queue has room, so the
  // upstream side never waits on a round in progress unless the queue is full.
  dtps_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .thread_select_i (thread_select_i),
    .task_value_i    (task_value_i),
    .task_priority_i (task_priority_i),
    .task_steps_i    (task_steps_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .cmd_pop_i       (cmd_pop)
  );

  // One table per context; both share the slot address driven by the sequencer,
  // which reads entries only from the table of the context it is serving.
  dtps_table #(
    .N    (TASKS_PER_CONTEXT),
    .IdxW (IdxW),
    .CntW (CntW)
  ) u_table0 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (tbl_wr[0]),
    .idx_i  (tbl_idx),
    .cnt_o  (tbl_cnt[0]),
    .rd_o   (tbl_rd[0])
  );

  dtps_table #(
    .N    (TASKS_PER_CONTEXT),
    .IdxW (IdxW),
    .CntW (CntW)
  ) u_table1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (tbl_wr[1]),
    .idx_i  (tbl_idx),
    .cnt_o  (tbl_cnt[1]),
    .rd_o   (tbl_rd[1])
  );

  // The back end serves context 0 then context 1 on a round, scanning for the
  // oldest highest-priority task, stepping it, and handing each result to the
  // output register as soon as the downstream side has taken the previous one.
  dtps_back #(
    .N    (TASKS_PER_CONTEXT),
    .IdxW (IdxW),
    .CntW (CntW)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (cmd),
    .cmd_pop_o       (cmd_pop),
    .wr_o            (tbl_wr),
    .idx_o           (tbl_idx),
    .cnt_i           (tbl_cnt),
    .rd_i            (tbl_rd),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .thread_o        (thread_o),
    .out_value_o     (out_value_o),
    .out_priority_o  (out_priority_o),
    .step_done_o     (step_done_o),
    .total_steps_o   (total_steps_o),
    .square_result_o (square_result_o),
    .last_o          (last_o)
  );

endmodule

>>> tb/sv/dual_thread_priority_task_stepper_core_tb.sv
// Self-checking testbench for the two-context priority task stepper core.
`timescale 1ns / 1ps

module dual_thread_priority_task_stepper_core_tb;
  import dtps_pkg::*;

  // The table depth is the block's default parameter value.
  localparam int TableDepth = 8;
  // Quiet time after the last report, long enough to cover anything still in flight.
  localparam int SettleCycles = 40;
  // The receiver's long hold-off, counted in cycles.
  localparam int HoldCycles = 400;
  // Cycles without any transfer before the run is declared hung.
  localparam int IdleLimit = 4000;
  localparam int RandomItems = 1390;

  // One pending task as the predictor keeps it.
  typedef struct {
    logic signed [15:0] value;
    logic [7:0]         pri;
    logic [7:0]         total;
    logic [7:0]         prog;
  } task_entry_t;

  // One report that the block is due to produce.
  typedef struct packed {
    kind_e              kind;
    logic               thread;
    logic signed [15:0] value;
    logic [7:0]         pri;
    logic [7:0]         done;
    logic [7:0]         total;
    logic [30:0]        square;
    logic               last;
  } report_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               req_type;
  logic               thread_select;
  logic signed [15:0] task_value;
  logic [7:0]         task_priority;
  logic [7:0]         task_steps;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         kind;
  logic               thread;
  logic signed [15:0] out_value;
  logic [7:0]         out_priority;
  logic [7:0]         step_done;
  logic [7:0]         total_steps;
  logic [30:0]        square_result;
  logic               last;

  // Predictor state: the two task tables, oldest entry at index 0.
  task_entry_t task_table [2][$];
  // Reports predicted but not yet seen at the output, oldest first.
  report_t     due_reports [$];

  int  mismatches;
  int  items_sent;
  int  reports_seen;
  int  kind_seen [4];
  int  idle_cycles;
  bit  no_idle;
  bit  hold_req;
  bit  hold_active;

  dual_thread_priority_task_stepper_core #(
    .TASKS_PER_CONTEXT(TableDepth)
  ) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .req_type_i      (req_type),
    .thread_select_i (thread_select),
    .task_value_i    (task_value),
    .task_priority_i (task_priority),
    .task_steps_i    (task_steps),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .kind_o          (kind),
    .thread_o        (thread),
    .out_value_o     (out_value),
    .out_priority_o  (out_priority),
    .step_done_o     (step_done),
    .total_steps_o   (total_steps),
    .square_result_o (square_result),
    .last_o          (last)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Idle gap length for either side: mostly none or short, now and then long.
  // During a no-idle stretch both sides run flat out.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Applies one accepted request to the predicted tables and queues the reports
  // it causes. A round steps context 0 and then context 1, each only when it
  // holds a task, and the last report of the request carries the last flag.
  task automatic predict_request(input req_e req, input logic ctx,
                                 input logic signed [15:0] value,
                                 input logic [7:0] pri, input logic [7:0] steps);
    task_entry_t entry;
    report_t     rpt;
    report_t     batch [$];
    int          best;
    int          mag;
    logic [7:0]  done;
    if (req == REQ_ADD) begin
      rpt = '{kind: KIND_ADD_OK, thread: ctx, value: value, pri: pri, done: 8'd0,
              total: steps, square: 31'd0, last: 1'b1};
      if (task_table[ctx].size() < TableDepth) begin
        entry = '{value: value, pri: pri, total: steps, prog: 8'd0};
        task_table[ctx] = {task_table[ctx], entry};
      end else begin
        // A full table leaves the state alone and echoes the offered task.
        rpt.kind = KIND_ADD_FULL;
      end
      due_reports = {due_reports, rpt};
    end else begin
      for (int c = 0; c < 2; c++) begin
        if (task_table[c].size() > 0) begin
          // Strictly greater wins, so the oldest task takes any tie.
          best = 0;
          for (int i = 1; i < task_table[c].size(); i++) begin
            if (task_table[c][i].pri > task_table[c][best].pri) best = i;
          end
          done = task_table[c][best].prog + 8'd1;
          task_table[c][best].prog = done;
          entry = task_table[c][best];
          rpt = '{kind: KIND_STEP, thread: c[0], value: entry.value, pri: entry.pri,
                  done: done, total: entry.total, square: 31'd0, last: 1'b0};
          if (done >= entry.total) begin
            mag = entry.value;
            if (mag < 0) mag = -mag;
            rpt.kind   = KIND_FINISH;
            rpt.square = 31'(mag * mag);
            task_table[c].delete(best);
          end
          batch = {batch, rpt};
        end
      end
      // A round over two empty tables causes no report at all.
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) due_reports = {due_reports, batch[i]};
    end
  endtask

  // Offers one request after a random gap, holds it until the transfer and
  // then hands it to the predictor. Valid is only lowered when a gap follows.
  task automatic send_request(input req_e req, input logic ctx,
                              input logic signed [15:0] value,
                              input logic [7:0] pri, input logic [7:0] steps);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    req_type      <= req;
    thread_select <= ctx;
    task_value    <= value;
    task_priority <= pri;
    task_steps    <= steps;
    do @(posedge clk); while (!in_ready);
    predict_request(req, ctx, value, pri, steps);
    items_sent++;
  endtask

  task automatic add_task(input logic ctx, input logic signed [15:0] value,
                          input logic [7:0] pri, input logic [7:0] steps);
    send_request(REQ_ADD, ctx, value, pri, steps);
  endtask

  // The payload of a round is don't-care, so it gets random content.
  task automatic run_round();
    send_request(REQ_ROUND, 1'($urandom()), 16'($urandom()), 8'($urandom()),
                 8'($urandom()));
  endtask

  // Stops offering, waits for every due report and lets the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_reports.size() > 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Random task content: priorities often drawn from a small set so that ties
  // happen, step counts mostly short so that tasks finish and tables compact.
  task automatic add_random_task(input logic ctx);
    logic [7:0] pri;
    logic [7:0] steps;
    int         roll;
    pri  = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom());
    roll = $urandom_range(0, 99);
    if (roll < 3)       steps = 8'd0;
    else if (roll < 85) steps = 8'($urandom_range(1, 6));
    else if (roll < 97) steps = 8'($urandom_range(7, 40));
    else                steps = 8'($urandom_range(41, 255));
    add_task(ctx, 16'($urandom()), pri, steps);
  endtask

  // Directed cases: value, priority and step extremes, both request types,
  // a round with nothing pending, a zero step count, the largest square,
  // an oldest-first tie and an add to a full table.
  task automatic test_directed();
    run_round();
    add_task(1'b0, -16'sd32768, 8'd255, 8'd0);
    run_round();
    add_task(1'b1, 16'sd32767, 8'd0, 8'd1);
    add_task(1'b1, -16'sd1, 8'd0, 8'd2);
    run_round();
    add_task(1'b1, 16'sd0, 8'd255, 8'd255);
    add_task(1'b1, 16'sh5555, 8'd128, 8'd3);
    add_task(1'b1, -16'sh5556, 8'd127, 8'd1);
    add_task(1'b1, 16'sh00ff, 8'd1, 8'd254);
    add_task(1'b1, -16'sh0100, 8'd254, 8'd2);
    add_task(1'b1, 16'sh7f00, 8'd64, 8'd128);
    add_task(1'b1, 16'sh00aa, 8'd255, 8'd1);
    add_task(1'b1, 16'sh1234, 8'd9, 8'd9);
    add_task(1'b0, 16'sd0, 8'd128, 8'd255);
    run_round();
    run_round();
    drain();
  endtask

  // Random mix. Most requests keep the tables cycling between adds and rounds;
  // now and then a burst of adds overflows one context, and a burst of rounds
  // steps the tasks of both contexts along. No-idle stretches come and go.
  task automatic test_random();
    int  roll;
    int  sent;
    logic ctx;
    sent = 0;
    while (sent < RandomItems) begin
      if (sent % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      ctx  = 1'($urandom());
      if (roll < 6) begin
        repeat (TableDepth + 2) begin
          add_random_task(ctx);
          sent++;
        end
      end else if (roll < 10) begin
        repeat (12) begin
          run_round();
          sent++;
        end
      end else if (roll < 55) begin
        add_random_task(ctx);
        sent++;
      end else begin
        run_round();
        sent++;
      end
    end
    no_idle = 1'b0;
    drain();
  endtask

  // The receiver stops for a long stretch while requests keep coming, so the
  // front queue and the result register fill and the input stalls.
  task automatic test_backpressure();
    hold_req = 1'b1;
    wait (hold_active);
    repeat (20) begin
      add_random_task(1'($urandom()));
      run_round();
    end
    drain();
  endtask

  // Short bursts, each followed by a full pause until every report is back.
  task automatic test_bursts();
    repeat (10) begin
      repeat (10) begin
        if ($urandom_range(0, 1) == 0) add_random_task(1'($urandom()));
        else run_round();
      end
      drain();
    end
  endtask

  // Receiver: ready in stretches with random gaps, plus one long hold-off
  // when the stimulus asks for it.
  initial begin
    int on_len;
    int gap;
    out_ready   = 1'b0;
    hold_active = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_ready   <= 1'b0;
        hold_active = 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_req    = 1'b0;
        hold_active = 1'b0;
      end
      on_len = $urandom_range(1, 12);
      out_ready <= 1'b1;
      repeat (on_len) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Checks every report transfer against the oldest due report.
  always @(posedge clk) begin
    report_t want;
    if (rst_n && out_valid && out_ready) begin
      reports_seen++;
      kind_seen[kind]++;
      if (due_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: report with none due: kind %0d thread %0d value %0d",
                   $realtime, kind, thread, out_value);
      end else begin
        want = due_reports.pop_front();
        if (kind !== want.kind || thread !== want.thread || out_value !== want.value ||
            out_priority !== want.pri || step_done !== want.done ||
            total_steps !== want.total || square_result !== want.square ||
            last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: report differs", $realtime);
            $display("  want kind %0d thr %0d val %0d pri %0d done %0d tot %0d sq %0d last %0d",
                     want.kind, want.thread, want.value, want.pri, want.done,
                     want.total, want.square, want.last);
            $display("  got  kind %0d thr %0d val %0d pri %0d done %0d tot %0d sq %0d last %0d",
                     kind, thread, out_value, out_priority, step_done, total_steps,
                     square_result, last);
          end
        end
      end
    end
  end

  // Watchdog: a run that stops moving for too long is a failure.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    mismatches    = 0;
    items_sent    = 0;
    reports_seen  = 0;
    idle_cycles   = 0;
    no_idle       = 1'b0;
    hold_req      = 1'b0;
    foreach (kind_seen[i]) kind_seen[i] = 0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    req_type      <= REQ_ADD;
    thread_select <= 1'b0;
    task_value    <= '0;
    task_priority <= '0;
    task_steps    <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random();
    test_backpressure();
    test_bursts();

    $display("Sent %0d requests, checked %0d reports.", items_sent, reports_seen);
    $display("Adds taken %0d, adds refused %0d, steps %0d, finished tasks %0d.",
             kind_seen[KIND_ADD_OK], kind_seen[KIND_ADD_FULL], kind_seen[KIND_STEP],
             kind_seen[KIND_FINISH]);
    if (mismatches == 0 && due_reports.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> dual_thread_priority_task_stepper_core.f
design/dtps_pkg.sv
design/dtps_front.sv
design/dtps_table.sv
design/dtps_back.sv
design/dual_thread_priority_task_stepper_core.sv
tb/sv/dual_thread_priority_task_stepper_core_tb.sv
